### rtl/mkds_pkg.sv
// ----------------------------------------------------------------------------
// mkds_pkg
// Shared widths, key code table and controller/datapath handshake types for
// the multi-key debounce scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mkds_pkg;

  localparam int PIN_W     = 14;   // raw key pins carried by one scan item
  localparam int KEY_SLOTS = 32;   // most keys the scanner can hold
  localparam int SLOT_W    = 5;    // bits to index KEY_SLOTS
  localparam int COUNT_W   = 9;
  localparam int THR_W     = 8;
  localparam int CODE_W    = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [THR_W-1:0]   HOLD_RESET = 8'd50;

  // Fixed code of each key slot.
  localparam logic [CODE_W-1:0] CODE_TABLE [KEY_SLOTS] = '{
    4'd2,  4'd5,  4'd8,  4'd0,  4'd11, 4'd9,  4'd6,  4'd3,
    4'd13, 4'd12, 4'd1,  4'd4,  4'd7,  4'd10, 4'd14, 4'd15,
    4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
    4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture pins, restart key index
    logic step;   // update one key's counter and arm flag
    logic emit;   // move the lowest pending event into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_key;    // key index is on the final key
    logic mask_empty;  // no events pending for this tick
    logic out_free;    // output register can take an item this cycle
  } status_t;

endpackage

`default_nettype wire

### rtl/mkds_ifs.sv
// ----------------------------------------------------------------------------
// mkds_ifs
// Valid/ready channels of the scanner: scan ticks in, key events out and the
// hold threshold write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkds_key_if import mkds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIN_W-1:0] key_pins_low;

  modport source (output valid, output key_pins_low, input ready);
  modport sink   (input valid, input key_pins_low, output ready);
endinterface

interface mkds_event_if import mkds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] key_code;
  logic              last_of_tick;

  modport source (output valid, output key_code, output last_of_tick, input ready);
  modport sink   (input valid, input key_code, input last_of_tick, output ready);
endinterface

interface mkds_cfg_if import mkds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] hold_threshold;

  modport source (output valid, output hold_threshold, input ready);
  modport sink   (input valid, input hold_threshold, output ready);
endinterface

`default_nettype wire

### rtl/multi_key_debounce_scanner.sv
// Order: an accepted tick walks all NUM_KEYS keys, one per cycle, and only
//   then are its events drained through the output register.
// Rate: a new tick is taken only after the walk and drain of the last one;
//   the walk covers one key per cycle over the counter array and the drain
//   hands out one event per cycle while the output register has room.
// Reset: synchronous; counters clear, all keys armed, threshold returns to 50.
// ----------------------------------------------------------------------------
// multi_key_debounce_scanner
// Debounces up to 32 active-low keys per scan tick and emits one key code
// per press once the hold count passes the programmed threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_key_debounce_scanner import mkds_pkg::*; #(
  parameter int NUM_KEYS = 14
) (
  input  wire logic    clk,
  input  wire logic    rst,
  mkds_key_if.sink     key_in,
  mkds_event_if.source event_out,
  mkds_cfg_if.sink     cfg
);

  cmd_t    cmd;
  status_t status;

  // Threshold writes are always taken, with no check by the block; the user must
  // write only while the scanner is idle, never in the middle of a key walk.
  assign cfg.ready = 1'b1;

  // Controller: idle -> scan (one key per cycle) -> drain pending events.
  // Ready is high only in idle, but the output register lets the last event
  // of a tick wait downstream while the next tick is taken.
  mkds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (key_in.valid),
    .in_ready (key_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: hold counters, arm flags, pending event mask, output register.
  // During the walk each qualifying key sets its bit in the mask; the drain
  // then hands out bits lowest first and marks the one that empties the mask.
  mkds_datapath #(
    .NUM_KEYS (NUM_KEYS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .key_pins_low  (key_in.key_pins_low),
    .cfg_valid     (cfg.valid),
    .cfg_threshold (cfg.hold_threshold),
    .out_valid     (event_out.valid),
    .out_ready     (event_out.ready),
    .out_code      (event_out.key_code),
    .out_last      (event_out.last_of_tick)
  );

  // Idle means every event of the previous tick has left the mask.
  a_idle_drained : assert property (@(posedge clk) disable iff (rst)
    key_in.ready |-> status.mask_empty)
    else $error("scanner idle with events still pending");

  // Drop ready right after a tick is taken: the walk must run first.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (key_in.valid && key_in.ready) |=> !key_in.ready)
    else $error("tick accepted while key walk in progress");

  // Emit only with a pending event and room in the output register.
  a_emit_legal : assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (status.out_free && !status.mask_empty))
    else $error("event emitted without room or without a pending event");

  // One command at a time.
  a_one_cmd : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.emit}))
    else $error("controller issued more than one command");

endmodule

`default_nettype wire

### rtl/mkds_ctrl.sv
// ----------------------------------------------------------------------------
// mkds_ctrl
// Sequencer: take a tick, walk the keys once, then drain pending events.
// ----------------------------------------------------------------------------
`default_nettype none

module mkds_ctrl import mkds_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.last_key) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.mask_empty) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/mkds_datapath.sv
// ----------------------------------------------------------------------------
// mkds_datapath
// Per-key hold counters and arm flags, pending event mask and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mkds_datapath import mkds_pkg::*; #(
  parameter int NUM_KEYS = 14
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  output status_t               status,
  input  wire logic [PIN_W-1:0] key_pins_low,
  input  wire logic             cfg_valid,
  input  wire logic [THR_W-1:0] cfg_threshold,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [CODE_W-1:0]     out_code,
  output logic                  out_last
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [THR_W-1:0]    threshold;
  logic [COUNT_W-1:0]  hold_count [NUM_KEYS];
  logic [NUM_KEYS-1:0] armed;
  logic [NUM_KEYS-1:0] mask;
  logic [NUM_KEYS-1:0] mask_next;
  logic [NUM_KEYS-1:0] pins;
  logic [IDX_W-1:0]    idx;

  logic [KEY_SLOTS-1:0] pins_wide;
  logic                 pressed;
  logic [COUNT_W-1:0]   cnt_cur;
  logic [COUNT_W-1:0]   cnt_inc;
  logic                 fire;
  logic [IDX_W-1:0]     sel;
  logic [NUM_KEYS-1:0]  mask_rest;

  // Keys past the pin field read level 0, so they count as pressed.
  assign pins_wide = KEY_SLOTS'(key_pins_low);

  assign pressed = ~pins[idx];
  assign cnt_cur = hold_count[idx];
  assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_W'(1);
  assign fire    = pressed && armed[idx] && (cnt_inc > COUNT_W'(threshold));

  // Lowest pending event goes out first.
  always_comb begin
    sel = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = IDX_W'(i);
      end
    end
  end

  assign mask_rest = mask & (mask - NUM_KEYS'(1));

  always_comb begin
    mask_next = mask;
    if (cmd.step && fire) begin
      mask_next[idx] = 1'b1;
    end
    if (cmd.emit) begin
      mask_next = mask_rest;
    end
  end

  assign status.last_key   = (idx == IDX_W'(NUM_KEYS - 1));
  assign status.mask_empty = (mask == '0);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pins <= pins_wide[NUM_KEYS-1:0];
    end
    if (cmd.emit) begin
      out_code <= CODE_TABLE[SLOT_W'(sel)];
      out_last <= (mask_rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= HOLD_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        hold_count[k] <= '0;
      end
      armed     <= '1;
      mask      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_threshold;
      end
      mask <= mask_next;
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.step) begin
        idx <= status.last_key ? '0 : idx + IDX_W'(1);
        if (pressed) begin
          hold_count[idx] <= cnt_inc;
          if (fire) begin
            armed[idx] <= 1'b0;
          end
        end else begin
          hold_count[idx] <= '0;
          armed[idx]      <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### tb/mkds_event_checker.sv
// ----------------------------------------------------------------------------
// mkds_event_checker
// Watches the scan, event and threshold channels of the scanner, predicts
// the key events of every accepted scan tick and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module mkds_event_checker import mkds_pkg::*; #(
  parameter int NUM_KEYS = 14
) (
  input  wire logic clk,
  input  wire logic rst,
  mkds_key_if       key_mon,
  mkds_event_if     event_mon,
  mkds_cfg_if       cfg_mon,
  output int        fail_count,
  output int        pending,
  output int        events_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int           SCAN_SLOTS        = (NUM_KEYS > 32) ? 32 : NUM_KEYS;
  localparam logic [8:0]   HOLD_SAT          = 9'd511;
  localparam logic [7:0]   THRESHOLD_DEFAULT = 8'd50;
  localparam int           PRINT_CAP         = 40;

  // Fixed code per key slot; slots past the pin width use index modulo 16.
  localparam logic [3:0] KEY_CODES [32] = '{
    4'd2,  4'd5,  4'd8,  4'd0,  4'd11, 4'd9,  4'd6,  4'd3,
    4'd13, 4'd12, 4'd1,  4'd4,  4'd7,  4'd10, 4'd14, 4'd15,
    4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
    4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
  };

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } key_event_t;

  key_event_t expected_events [$];
  logic [8:0] hold_ticks [32];
  logic       key_armed  [32];
  logic [7:0] threshold;

  initial begin
    fail_count     = 0;
    pending        = 0;
    events_checked = 0;
  end

  task automatic report(input string msg);
    if (fail_count < PRINT_CAP) $display("%0t ns  mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Walk the keys in index order and queue the events this tick causes.
  task automatic predict_scan(input logic [PIN_W-1:0] pins);
    int         first_new;
    logic       pressed;
    key_event_t tail;
    first_new = expected_events.size();
    for (int k = 0; k < SCAN_SLOTS; k++) begin
      pressed = (k < PIN_W) ? ~pins[k] : 1'b1;
      if (pressed) begin
        if (hold_ticks[k] != HOLD_SAT) hold_ticks[k] = hold_ticks[k] + 9'd1;
        if (hold_ticks[k] > {1'b0, threshold} && key_armed[k]) begin
          expected_events.push_back(key_event_t'{KEY_CODES[k], 1'b0});
          key_armed[k] = 1'b0;
        end
      end else begin
        hold_ticks[k] = '0;
        key_armed[k]  = 1'b1;
      end
    end
    if (expected_events.size() > first_new) begin
      tail      = expected_events.pop_back();
      tail.last = 1'b1;
      expected_events.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    key_event_t want;
    if (rst) begin
      expected_events.delete();
      threshold = THRESHOLD_DEFAULT;
      for (int k = 0; k < 32; k++) begin
        hold_ticks[k] = '0;
        key_armed[k]  = 1'b1;
      end
    end else begin
      // Compare first: events of a tick never leave in its own cycle.
      if (event_mon.valid && event_mon.ready) begin
        events_checked++;
        if (expected_events.size() == 0) begin
          report($sformatf("event code %0d last %0b with nothing expected",
                           event_mon.key_code, event_mon.last_of_tick));
        end else begin
          want = expected_events.pop_front();
          if (event_mon.key_code !== want.code)
            report($sformatf("key_code %0d, expected %0d", event_mon.key_code, want.code));
          if (event_mon.last_of_tick !== want.last)
            report($sformatf("last_of_tick %0b, expected %0b (code %0d)",
                             event_mon.last_of_tick, want.last, want.code));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) threshold = cfg_mon.hold_threshold;
      if (key_mon.valid && key_mon.ready) predict_scan(key_mon.key_pins_low);
    end
    pending <= expected_events.size();
  end

endmodule

`default_nettype wire

### tb/multi_key_debounce_scanner_tb.sv
// ----------------------------------------------------------------------------
// multi_key_debounce_scanner_tb
// Drives scan ticks of key pin levels and hold threshold writes into the
// scanner, with random gaps and output stalls; the event checker beside the
// block predicts and compares every key event.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_key_debounce_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mkds_pkg::*;

  localparam int NUM_KEYS     = 14;
  localparam int CYCLE_LIMIT  = 500000;
  // An idle tick causes no event, so after the last event the block may still
  // be walking keys; give it a full walk plus margin before touching config.
  localparam int DRAIN_SETTLE = NUM_KEYS + 4;

  logic clk;
  logic rst;
  logic no_idle;        // when set, neither side inserts gaps or stalls
  int   ticks_sent;
  int   cycle_count;
  int   fail_count;
  int   pending;
  int   events_checked;

  // Per-key press model for the random part: current level and ticks left in it.
  logic key_down   [PIN_W];
  int   phase_left [PIN_W];

  mkds_key_if   key_bus ();
  mkds_event_if event_bus ();
  mkds_cfg_if   cfg_bus ();

  multi_key_debounce_scanner #(.NUM_KEYS(NUM_KEYS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .key_in    (key_bus),
    .event_out (event_bus),
    .cfg       (cfg_bus)
  );

  mkds_event_checker #(.NUM_KEYS(NUM_KEYS)) event_check (
    .clk            (clk),
    .rst            (rst),
    .key_mon        (key_bus),
    .event_mon      (event_bus),
    .cfg_mon        (cfg_bus),
    .fail_count     (fail_count),
    .pending        (pending),
    .events_checked (events_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run guard: end the run as failed if the stimulus never completes.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d events still expected", cycle_count, pending);
    $display("multi_key_debounce_scanner_tb: FAIL");
    $finish;
  end

  // Offer one scan tick after a random gap and hold it until accepted.
  // Keep valid high between back-to-back items; drop it only for a gap.
  task automatic send_tick(input logic [PIN_W-1:0] pins);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      key_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_bus.valid        <= 1'b1;
    key_bus.key_pins_low <= pins;
    do @(posedge clk); while (!key_bus.ready);
    ticks_sent++;
  endtask

  // Hold off the sender until every predicted event has left the block, then
  // let the key walk of a final event-free tick finish.
  task automatic wait_drain();
    key_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  // Write the hold threshold while the block is idle.
  task automatic set_threshold(input logic [7:0] value);
    wait_drain();
    cfg_bus.valid          <= 1'b1;
    cfg_bus.hold_threshold <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // Advance every key's press model by one tick. Presses last up to max_hold
  // ticks so they land on both sides of the threshold; releases are short.
  // With bounce on, flip one random pin now and then.
  task automatic advance_keys(input int max_hold, input logic bounce,
                              output logic [PIN_W-1:0] pins);
    for (int k = 0; k < PIN_W; k++) begin
      if (phase_left[k] == 0) begin
        key_down[k]   = ~key_down[k];
        phase_left[k] = key_down[k] ? $urandom_range(1, max_hold) : $urandom_range(1, 4);
      end
      phase_left[k]--;
      pins[k] = ~key_down[k];
    end
    if (bounce && $urandom_range(0, 9) == 0)
      pins[$urandom_range(0, PIN_W - 1)] ^= 1'b1;
  endtask

  // One random phase at a fixed threshold: mostly realistic press sequences,
  // with noise some fully random pin words, and one drain pause halfway through.
  task automatic run_phase(input logic [7:0] thr, input int n_items,
                           input logic burst, input logic noisy);
    logic [PIN_W-1:0] pins;
    int               max_hold;
    set_threshold(thr);
    no_idle  = burst;
    max_hold = (thr < 40) ? thr + 4 : 300;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_drain();
      advance_keys(max_hold, noisy, pins);
      if (noisy && $urandom_range(0, 9) == 0) pins = PIN_W'($urandom);
      send_tick(pins);
    end
    no_idle = 1'b0;
  endtask

  // Event receiver: stall a random number of cycles before each item.
  initial begin
    int stall;
    event_bus.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        event_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      event_bus.ready <= 1'b1;
      do @(posedge clk); while (!event_bus.valid);
    end
  end

  initial begin
    logic [PIN_W-1:0] zero_thr_ticks [10];
    zero_thr_ticks = '{14'h3FFF, 14'h0000, 14'h0000, 14'h3FFF, 14'h2AAA,
                       14'h1555, 14'h3FFE, 14'h1FFF, 14'h3FFF, 14'h0000};

    rst                    <= 1'b1;
    key_bus.valid          <= 1'b0;
    key_bus.key_pins_low   <= '1;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.hold_threshold <= '0;
    no_idle    = 1'b0;
    ticks_sent = 0;
    for (int k = 0; k < PIN_W; k++) begin
      key_down[k]   = 1'b0;
      phase_left[k] = $urandom_range(1, 4);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset threshold of 50: two ticks cannot qualify anything.
    send_tick(14'h0000);
    send_tick(14'h3FFF);

    // Threshold zero: every armed key fires on its first pressed tick; all
    // keys at once give fourteen events; a held key stays silent after firing.
    set_threshold(8'd0);
    foreach (zero_thr_ticks[i]) send_tick(zero_thr_ticks[i]);

    // Threshold one: the second pressed tick fires.
    set_threshold(8'd1);
    send_tick(14'h3FFF);
    send_tick(14'h0000);
    send_tick(14'h0000);
    send_tick(14'h0000);

    // Highest threshold: a short press never fires.
    set_threshold(8'd255);
    send_tick(14'h0000);
    send_tick(14'h3FFF);

    // Random part.
    run_phase(8'd0, 50, 1'b0, 1'b1);
    run_phase(8'd1, 50, 1'b1, 1'b1);
    run_phase(8'($urandom_range(2, 8)), 60, 1'b0, 1'b1);

    // Long hold: keep two keys down through the whole phase, without noise,
    // so each fires once partway through and stays silent for the rest.
    key_down[0]   = 1'b1;
    phase_left[0] = 1000;
    key_down[5]   = 1'b1;
    phase_left[5] = 1000;
    run_phase(8'd150, 190, 1'b0, 1'b0);
    phase_left[0] = 1;
    phase_left[5] = 1;

    run_phase(8'd50, 60, 1'b0, 1'b1);
    run_phase(8'd3, 50, 1'b0, 1'b1);

    // Drain, then watch a while longer for stray events.
    wait_drain();
    repeat (2 * NUM_KEYS) @(posedge clk);

    $display("covered %0d scan ticks and %0d key events at thresholds 0, 1, 3, 50, 150, 255",
             ticks_sent, events_checked);
    $display("with random gaps and stalls, drain pauses and two long unbroken holds");
    if (fail_count == 0) begin
      $display("multi_key_debounce_scanner_tb: PASS");
    end else begin
      $display("multi_key_debounce_scanner_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/mkds_pkg.sv
rtl/mkds_ifs.sv
rtl/mkds_ctrl.sv
rtl/mkds_datapath.sv
rtl/multi_key_debounce_scanner.sv
tb/mkds_event_checker.sv
tb/multi_key_debounce_scanner_tb.sv
